// ===== hdl/qeva_pkg.sv =====
// Shared types, register codes and the phase decode table for the
// quadrature encoder value adjuster. No dependencies.
`timescale 1ns / 1ps

package qeva_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE_MASK   = 3'd0,
    REG_UNSIGNED_STEP = 3'd1,
    REG_SIGNED_STEP   = 3'd2,
    REG_FIXED_STEP    = 3'd3,
    REG_FIXED_MIN     = 3'd4,
    REG_FIXED_MAX     = 3'd5
  } cfg_reg_t;

  // Bits of enable_mask
  localparam int unsigned EN_UNSIGNED = 0;
  localparam int unsigned EN_SIGNED   = 1;
  localparam int unsigned EN_FIXED    = 2;

  localparam logic [15:0] U16_MAX = 16'hffff;

  // Step codes
  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_UP   = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN = 2'sb11;

  typedef struct packed {
    logic [2:0]         enable_mask;
    logic [15:0]        unsigned_step;
    logic signed [15:0] signed_step;
    logic signed [31:0] fixed_step;
    logic signed [31:0] fixed_min;
    logic signed [31:0] fixed_max;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic up;
  } detent_t;

  // Gray-code transition decode: previous pair against current pair
  function automatic logic signed [1:0] decode_step(input logic [1:0] prev,
                                                    input logic [1:0] cur);
    logic signed [1:0] s;
    case ({prev, cur})
      4'b0001: s = STEP_UP;
      4'b0111: s = STEP_UP;
      4'b1000: s = STEP_UP;
      4'b1110: s = STEP_UP;
      4'b0010: s = STEP_DOWN;
      4'b0100: s = STEP_DOWN;
      4'b1011: s = STEP_DOWN;
      4'b1101: s = STEP_DOWN;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/qeva_sample_if.sv =====
// Input channel of the value adjuster: one sample of both encoder phases.
// No dependencies.
`timescale 1ns / 1ps

interface qeva_sample_if;
  logic valid;
  logic ready;
  logic phase_a;
  logic phase_b;

  modport source (output valid, output phase_a, output phase_b, input ready);
  modport sink   (input valid, input phase_a, input phase_b, output ready);
endinterface

// ===== hdl/qeva_result_if.sv =====
// Result channel of the value adjuster: position, step and adjusted values.
// No dependencies.
`timescale 1ns / 1ps

interface qeva_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [1:0]  step;
  logic [15:0]        unsigned_value;
  logic signed [15:0] signed_value;
  logic signed [31:0] fixed_value;

  modport source (output valid, output position, output step, output unsigned_value,
                  output signed_value, output fixed_value, input ready);
  modport sink   (input valid, input position, input step, input unsigned_value,
                  input signed_value, input fixed_value, output ready);
endinterface

// ===== hdl/quadrature_encoder_value_adjuster.sv =====
// Top level of the quadrature encoder value adjuster: configuration
// registers, decoder, value adjuster and result register.
// Depends on qeva_pkg, qeva_sample_if, qeva_result_if, qeva_decoder, qeva_adjust.
//
// Usage:
//   sample  - sink channel, one pair of phase levels (phase_a, phase_b) per item.
//   result  - source channel, one item per sample: position, step and the
//             three adjusted values after that sample.
//   cfg_we/cfg_index/cfg_data - register write port, taken at any edge with
//             cfg_we high; indexes beyond the last register are ignored.
//             Write only while no item is in flight.
// Each accepted sample's result is written into the output register at the
// edge that accepts it. Throughput: one sample per cycle while the result
// register is free or being taken; the decode, position add and the 33-bit
// clamp of the fixed value all settle between the state and result registers.
// Stall: sample.ready stays high while the result register is empty or being
// taken this cycle, so a stalled receiver holds one result and back-pressures
// the sample channel; no item is dropped.
// Reset: rst (synchronous) clears all state and values to zero, empties the
// result register and restores the register defaults.
`timescale 1ns / 1ps

module quadrature_encoder_value_adjuster (
  input  logic                  clk,
  input  logic                  rst,
  qeva_sample_if.sink           sample,
  qeva_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  qeva_pkg::cfg_t     cfg;
  qeva_pkg::detent_t  detent;
  logic               accept;
  logic signed [1:0]  step;
  logic signed [31:0] position_next;
  logic [15:0]        unsigned_next;
  logic signed [15:0] signed_next;
  logic signed [31:0] fixed_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mask   <= 3'd0;
      cfg.unsigned_step <= 16'd1;
      cfg.signed_step   <= 16'sd1;
      cfg.fixed_step    <= 32'sd65536;
      cfg.fixed_min     <= 32'sd0;
      cfg.fixed_max     <= 32'sd6553600;
    end else if (cfg_we) begin
      case (cfg_index)
        qeva_pkg::REG_ENABLE_MASK:   cfg.enable_mask   <= cfg_data[2:0];
        qeva_pkg::REG_UNSIGNED_STEP: cfg.unsigned_step <= cfg_data[15:0];
        qeva_pkg::REG_SIGNED_STEP:   cfg.signed_step   <= cfg_data[15:0];
        qeva_pkg::REG_FIXED_STEP:    cfg.fixed_step    <= cfg_data;
        qeva_pkg::REG_FIXED_MIN:     cfg.fixed_min     <= cfg_data;
        qeva_pkg::REG_FIXED_MAX:     cfg.fixed_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a sample whenever the result register is free or draining
  assign sample.ready = ~result.valid | result.ready;
  assign accept       = sample.valid & sample.ready;

  qeva_decoder u_decoder (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .phase_a       (sample.phase_a),
    .phase_b       (sample.phase_b),
    .step          (step),
    .position_next (position_next),
    .detent        (detent)
  );

  qeva_adjust u_adjust (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .detent        (detent),
    .cfg           (cfg),
    .unsigned_next (unsigned_next),
    .signed_next   (signed_next),
    .fixed_next    (fixed_next)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.position       <= position_next;
      result.step           <= step;
      result.unsigned_value <= unsigned_next;
      result.signed_value   <= signed_next;
      result.fixed_value    <= fixed_next;
    end
  end

endmodule

// ===== hdl/qeva_decoder.sv =====
// Phase decoder: step decode, wrapping position and detent counter.
// Depends on qeva_pkg.
`timescale 1ns / 1ps

module qeva_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               phase_a,
  input  logic               phase_b,
  output logic signed [1:0]  step,
  output logic signed [31:0] position_next,
  output qeva_pkg::detent_t  detent
);

  logic [1:0]         previous_phases;
  logic signed [31:0] position_count;
  logic signed [1:0]  detent_count;
  logic signed [1:0]  detent_count_next;
  logic [1:0]         cur;
  logic signed [2:0]  detent_sum;

  // Decode this sample against the previous pair
  assign cur  = {phase_b, phase_a};
  assign step = qeva_pkg::decode_step(previous_phases, cur);

  assign position_next = position_count + {{30{step[1]}}, step};

  // Detent fires at two net counts in one direction
  assign detent_sum  = {detent_count[1], detent_count} + {step[1], step};
  assign detent.fire = (detent_sum == 3'sb010) || (detent_sum == 3'sb110);
  assign detent.up   = ~detent_sum[2];
  assign detent_count_next = detent.fire ? 2'sb00 : detent_sum[1:0];

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_phases <= 2'b00;
      position_count  <= 32'sd0;
      detent_count    <= 2'sb00;
    end else if (accept) begin
      previous_phases <= cur;
      position_count  <= position_next;
      detent_count    <= detent_count_next;
    end
  end

endmodule

// ===== hdl/qeva_adjust.sv =====
// Value adjuster: unsigned (skip out of range), signed (wrap) and Q16.16
// fixed (clamp and saturate) values moved on each detent. Depends on qeva_pkg.
`timescale 1ns / 1ps

module qeva_adjust (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  qeva_pkg::detent_t  detent,
  input  qeva_pkg::cfg_t     cfg,
  output logic [15:0]        unsigned_next,
  output logic signed [15:0] signed_next,
  output logic signed [31:0] fixed_next
);

  logic [15:0]        unsigned_store;
  logic signed [15:0] signed_store;
  logic signed [31:0] fixed_store;

  logic [16:0]        u_sum;
  logic signed [32:0] f_store_x;
  logic signed [32:0] f_step_x;
  logic signed [32:0] f_min_x;
  logic signed [32:0] f_max_x;
  logic signed [32:0] f_raw;
  logic signed [32:0] f_clamped;
  logic signed [31:0] f_sat;
  logic               f_apply;
  logic               s_apply;
  logic               u_apply;

  assign f_apply = detent.fire && cfg.enable_mask[qeva_pkg::EN_FIXED];
  assign s_apply = detent.fire && cfg.enable_mask[qeva_pkg::EN_SIGNED];
  assign u_apply = detent.fire && cfg.enable_mask[qeva_pkg::EN_UNSIGNED];

  // Unsigned: skip a change that leaves the 16-bit range
  assign u_sum = {1'b0, unsigned_store} + {1'b0, cfg.unsigned_step};
  always_comb begin
    unsigned_next = unsigned_store;
    if (u_apply) begin
      if (detent.up) begin
        if (!u_sum[16]) unsigned_next = u_sum[15:0];
      end else begin
        if (unsigned_store >= cfg.unsigned_step)
          unsigned_next = unsigned_store - cfg.unsigned_step;
      end
    end
  end

  // Signed: wrap modulo 2^16
  always_comb begin
    signed_next = signed_store;
    if (s_apply) begin
      signed_next = detent.up ? signed_store + cfg.signed_step
                              : signed_store - cfg.signed_step;
    end
  end

  // Fixed: exact sum, clamp against the limit of that direction, then saturate
  assign f_store_x = {fixed_store[31], fixed_store};
  assign f_step_x  = {cfg.fixed_step[31], cfg.fixed_step};
  assign f_min_x   = {cfg.fixed_min[31], cfg.fixed_min};
  assign f_max_x   = {cfg.fixed_max[31], cfg.fixed_max};
  assign f_raw     = detent.up ? f_store_x + f_step_x : f_store_x - f_step_x;

  always_comb begin
    f_clamped = f_raw;
    if (detent.up) begin
      if (f_raw > f_max_x)
        f_clamped = f_max_x;
    end else begin
      if (f_raw < f_min_x)
        f_clamped = f_min_x;
    end
  end

  always_comb begin
    if (f_clamped[32] != f_clamped[31])
      f_sat = f_clamped[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else
      f_sat = f_clamped[31:0];
  end

  assign fixed_next = f_apply ? f_sat : fixed_store;

  // Hold values between items, update on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      unsigned_store <= 16'd0;
      signed_store   <= 16'sd0;
      fixed_store    <= 32'sd0;
    end else if (accept) begin
      unsigned_store <= unsigned_next;
      signed_store   <= signed_next;
      fixed_store    <= fixed_next;
    end
  end

endmodule
